// ===== hw/rtl/lavm_pkg.sv =====
// shared types, constants and arithmetic helpers for the look-at matrix block
`default_nettype none

package lavm_pkg;

   // number format
   localparam int FRAC_BITS = 16;
   localparam int WORD_BITS = 32;
   localparam int THR_W     = 17;

   // derived widths
   localparam int SU_W   = WORD_BITS - 1;
   localparam int SUM_W  = 2 * WORD_BITS;
   localparam int PROD_W = 2 * WORD_BITS;
   localparam int REM_W  = WORD_BITS + 3;
   localparam int NUM_W  = WORD_BITS + FRAC_BITS;
   localparam int Q_W    = FRAC_BITS + 1;
   localparam int SH_W   = $clog2(WORD_BITS);

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic [2:0][WORD_BITS-1:0]   vec_type;

   localparam word_type WMAX  = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WMIN  = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam word_type ONE_Q = word_type'(64'd1 << FRAC_BITS);

   // matrix rows
   localparam logic [1:0] ROW_RIGHT = 2'd0;
   localparam logic [1:0] ROW_UP    = 2'd1;
   localparam logic [1:0] ROW_BACK  = 2'd2;
   localparam logic [1:0] ROW_TRANS = 2'd3;

   typedef struct packed {
      logic [REM_W-1:0]     rem;
      logic [WORD_BITS-1:0] root;
   } sq_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] rem;
      logic                 qbit;
   } dv_type;

   // clamp a one-bit-wider value into the word
   function automatic word_type sat_word(input logic [WORD_BITS:0] x);
      word_type res;
      if (x[WORD_BITS] != x[WORD_BITS-1]) begin
         res = x[WORD_BITS] ? WMIN : WMAX;
      end else begin
         res = x[WORD_BITS-1:0];
      end
      return res;
   endfunction

   // magnitude of a word, fits unsigned in the word width
   function automatic logic [WORD_BITS-1:0] mag_word(input logic [WORD_BITS-1:0] x);
      logic [WORD_BITS-1:0] res;
      if (x[WORD_BITS-1]) begin
         res = (~x) + 1'b1;
      end else begin
         res = x;
      end
      return res;
   endfunction

   // round a product magnitude to nearest, ties away, then apply sign and clamp
   function automatic word_type round_prod(input logic [PROD_W-1:0] p, input logic neg);
      logic [PROD_W:0]           t;
      logic [PROD_W-FRAC_BITS:0] r;
      word_type                  res;
      t = {1'b0, p} + ((PROD_W+1)'(1) << (FRAC_BITS - 1));
      r = t[PROD_W:FRAC_BITS];
      if (neg) begin
         if (r > (PROD_W-FRAC_BITS+1)'({1'b1, {(WORD_BITS-1){1'b0}}})) begin
            res = WMIN;
         end else begin
            res = word_type'(~r[WORD_BITS-1:0] + 1'b1);
         end
      end else begin
         if (r > (PROD_W-FRAC_BITS+1)'(WMAX)) begin
            res = WMAX;
         end else begin
            res = r[WORD_BITS-1:0];
         end
      end
      return res;
   endfunction

   // one result bit of the square root
   function automatic sq_type sqrt_step(input logic [REM_W-1:0] rem,
                                        input logic [WORD_BITS-1:0] root,
                                        input logic [1:0] pair);
      logic [REM_W-1:0] sh;
      logic [REM_W-1:0] trial;
      sq_type           res;
      sh    = {rem[WORD_BITS:0], pair};
      trial = {1'b0, root, 2'b01};
      if (sh >= trial) begin
         res.rem  = sh - trial;
         res.root = {root[WORD_BITS-2:0], 1'b1};
      end else begin
         res.rem  = sh;
         res.root = {root[WORD_BITS-2:0], 1'b0};
      end
      return res;
   endfunction

   // one quotient bit of the restoring divide
   function automatic dv_type div_step(input logic [WORD_BITS-1:0] rem,
                                       input logic [WORD_BITS-1:0] len,
                                       input logic nbit);
      logic [WORD_BITS:0] sh;
      logic [WORD_BITS:0] diff;
      dv_type             res;
      sh   = {rem, nbit};
      diff = sh - {1'b0, len};
      if (sh >= {1'b0, len}) begin
         res.rem  = diff[WORD_BITS-1:0];
         res.qbit = 1'b1;
      end else begin
         res.rem  = sh[WORD_BITS-1:0];
         res.qbit = 1'b0;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lavm_norm.sv =====
// pipelined vector normalizer: scale, sum of squares, square root, divide
`default_nettype none

module lavm_norm #(
   parameter int NVEC   = 1,
   parameter int SIDE_W = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  lavm_pkg::vec_type          in_vec [NVEC],
   input  logic [lavm_pkg::THR_W-1:0] thr,
   input  logic [SIDE_W-1:0]          in_side,
   output logic                       out_valid,
   output lavm_pkg::vec_type          out_vec [NVEC],
   output logic [NVEC-1:0]            out_deg,
   output logic [SIDE_W-1:0]          out_side
);
   import lavm_pkg::*;

   localparam int W   = WORD_BITS;
   localparam int T   = THR_W;
   localparam int LAT = 6 + W + 1 + Q_W + 1;

   logic [LAT-1:0]    vld_ff;
   logic [SIDE_W-1:0] side_ff [LAT];

   // front stages
   vec_type                   v1_ff [NVEC];
   vec_type                   v2_ff [NVEC];
   vec_type                   v3_ff [NVEC];
   vec_type                   v4_ff [NVEC];
   vec_type                   v5_ff [NVEC];
   vec_type                   v6_ff [NVEC];
   vec_type                   mag1_ff [NVEC];
   vec_type                   mag2_ff [NVEC];
   vec_type                   mag3_ff [NVEC];
   logic [W-1:0]              m2_ff [NVEC];
   logic [2:0][2*T-1:0]       lo2_ff [NVEC];
   logic [2*T-1:0]            thr2_ff;
   logic [2*T-1:0]            thr3_ff;
   logic [2*T+1:0]            ssum3_ff [NVEC];
   logic                      z3_ff [NVEC];
   logic                      lowm3_ff [NVEC];
   logic                      shr3_ff [NVEC];
   logic [SH_W-1:0]           shl3_ff [NVEC];
   logic                      deg4_ff [NVEC];
   logic                      deg5_ff [NVEC];
   logic                      deg6_ff [NVEC];
   logic [2:0][SU_W-1:0]      su4_ff [NVEC];
   logic [2:0][SU_W-1:0]      su5_ff [NVEC];
   logic [2:0][SU_W-1:0]      su6_ff [NVEC];
   logic [2:0][2*SU_W-1:0]    sq5_ff [NVEC];
   logic [SUM_W-1:0]          s6_ff [NVEC];

   // square root stages
   vec_type                   qv_ff [NVEC][W];
   logic                      qd_ff [NVEC][W];
   logic [2:0][SU_W-1:0]      qsu_ff [NVEC][W];
   logic [SUM_W-1:0]          qs_ff [NVEC][W];
   logic [REM_W-1:0]          qrem_ff [NVEC][W];
   logic [W-1:0]              qroot_ff [NVEC][W];

   // dividend setup
   vec_type                   nv_ff [NVEC];
   logic                      nd_ff [NVEC];
   logic [2:0][NUM_W-1:0]     num_ff [NVEC];
   logic [W-1:0]              len_ff [NVEC];

   // divide stages
   vec_type                   dv_ff [NVEC][Q_W];
   logic                      dd_ff [NVEC][Q_W];
   logic [2:0][NUM_W-1:0]     dn_ff [NVEC][Q_W];
   logic [W-1:0]              dl_ff [NVEC][Q_W];
   logic [2:0][W-1:0]         drem_ff [NVEC][Q_W];
   logic [2:0][Q_W-1:0]       dq_ff [NVEC][Q_W];

   // output stage
   vec_type                   ov_ff [NVEC];
   logic [NVEC-1:0]           od_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], in_valid};
      end
   end

   // side data rides along with the item
   always_ff @(posedge clock) begin
      side_ff[0] <= in_side;
      for (int s = 1; s < LAT; s++) begin
         side_ff[s] <= side_ff[s-1];
      end
   end

   // datapath, free running: nothing downstream can stall
   always_ff @(posedge clock) begin
      logic [W-1:0]  mx;
      int            pos;
      logic [W-1:0]  sh;
      sq_type        st;
      dv_type        dst;
      logic [W-1:0]  qv;
      thr2_ff <= thr * thr;
      thr3_ff <= thr2_ff;
      for (int l = 0; l < NVEC; l++) begin
         // magnitudes
         v1_ff[l] <= in_vec[l];
         for (int i = 0; i < 3; i++) begin
            mag1_ff[l][i] <= mag_word(in_vec[l][i]);
         end
         // largest component and small-range squares
         v2_ff[l]   <= v1_ff[l];
         mag2_ff[l] <= mag1_ff[l];
         mx = mag1_ff[l][0];
         if (mag1_ff[l][1] > mx) mx = mag1_ff[l][1];
         if (mag1_ff[l][2] > mx) mx = mag1_ff[l][2];
         m2_ff[l] <= mx;
         for (int i = 0; i < 3; i++) begin
            lo2_ff[l][i] <= mag1_ff[l][i][T-1:0] * mag1_ff[l][i][T-1:0];
         end
         // leading one search and short-vector test
         v3_ff[l]    <= v2_ff[l];
         mag3_ff[l]  <= mag2_ff[l];
         z3_ff[l]    <= (m2_ff[l] == '0);
         lowm3_ff[l] <= (m2_ff[l] < W'(thr));
         ssum3_ff[l] <= (2*T+2)'(lo2_ff[l][0]) + (2*T+2)'(lo2_ff[l][1])
                        + (2*T+2)'(lo2_ff[l][2]);
         shr3_ff[l]  <= m2_ff[l][W-1];
         pos = 0;
         for (int b = 0; b < W - 1; b++) begin
            if (m2_ff[l][b]) pos = b;
         end
         shl3_ff[l] <= SH_W'(W - 2 - pos);
         // degenerate flag and scaled magnitudes
         v4_ff[l]   <= v3_ff[l];
         deg4_ff[l] <= z3_ff[l] | (lowm3_ff[l] & (ssum3_ff[l] < (2*T+2)'(thr3_ff)));
         for (int i = 0; i < 3; i++) begin
            sh = shr3_ff[l] ? (mag3_ff[l][i] >> 1) : (mag3_ff[l][i] << shl3_ff[l]);
            su4_ff[l][i] <= sh[SU_W-1:0];
         end
         // squares
         v5_ff[l]   <= v4_ff[l];
         deg5_ff[l] <= deg4_ff[l];
         su5_ff[l]  <= su4_ff[l];
         for (int i = 0; i < 3; i++) begin
            sq5_ff[l][i] <= su4_ff[l][i] * su4_ff[l][i];
         end
         // sum of squares
         v6_ff[l]   <= v5_ff[l];
         deg6_ff[l] <= deg5_ff[l];
         su6_ff[l]  <= su5_ff[l];
         s6_ff[l]   <= SUM_W'(sq5_ff[l][0]) + SUM_W'(sq5_ff[l][1]) + SUM_W'(sq5_ff[l][2]);
         // square root, one result bit per stage
         st = sqrt_step('0, '0, s6_ff[l][SUM_W-2 +: 2]);
         qv_ff[l][0]    <= v6_ff[l];
         qd_ff[l][0]    <= deg6_ff[l];
         qsu_ff[l][0]   <= su6_ff[l];
         qs_ff[l][0]    <= s6_ff[l];
         qrem_ff[l][0]  <= st.rem;
         qroot_ff[l][0] <= st.root;
         for (int k = 1; k < W; k++) begin
            st = sqrt_step(qrem_ff[l][k-1], qroot_ff[l][k-1],
                           qs_ff[l][k-1][2*(W-1-k) +: 2]);
            qv_ff[l][k]    <= qv_ff[l][k-1];
            qd_ff[l][k]    <= qd_ff[l][k-1];
            qsu_ff[l][k]   <= qsu_ff[l][k-1];
            qs_ff[l][k]    <= qs_ff[l][k-1];
            qrem_ff[l][k]  <= st.rem;
            qroot_ff[l][k] <= st.root;
         end
         // dividend with half the length added for rounding
         nv_ff[l]  <= qv_ff[l][W-1];
         nd_ff[l]  <= qd_ff[l][W-1];
         len_ff[l] <= qroot_ff[l][W-1];
         for (int i = 0; i < 3; i++) begin
            num_ff[l][i] <= NUM_W'({qsu_ff[l][W-1][i], {FRAC_BITS{1'b0}}})
                            + NUM_W'(qroot_ff[l][W-1] >> 1);
         end
         // divide, one quotient bit per stage
         dv_ff[l][0] <= nv_ff[l];
         dd_ff[l][0] <= nd_ff[l];
         dn_ff[l][0] <= num_ff[l];
         dl_ff[l][0] <= len_ff[l];
         for (int i = 0; i < 3; i++) begin
            dst = div_step(W'(num_ff[l][i][NUM_W-1:Q_W]), len_ff[l], num_ff[l][i][Q_W-1]);
            drem_ff[l][0][i] <= dst.rem;
            dq_ff[l][0][i]   <= Q_W'(dst.qbit);
         end
         for (int j = 1; j < Q_W; j++) begin
            dv_ff[l][j] <= dv_ff[l][j-1];
            dd_ff[l][j] <= dd_ff[l][j-1];
            dn_ff[l][j] <= dn_ff[l][j-1];
            dl_ff[l][j] <= dl_ff[l][j-1];
            for (int i = 0; i < 3; i++) begin
               dst = div_step(drem_ff[l][j-1][i], dl_ff[l][j-1], dn_ff[l][j-1][i][Q_W-1-j]);
               drem_ff[l][j][i] <= dst.rem;
               dq_ff[l][j][i]   <= {dq_ff[l][j-1][i][Q_W-2:0], dst.qbit};
            end
         end
         // sign and degenerate bypass
         od_ff[l] <= dd_ff[l][Q_W-1];
         for (int i = 0; i < 3; i++) begin
            qv = W'(dq_ff[l][Q_W-1][i]);
            if (dd_ff[l][Q_W-1]) begin
               ov_ff[l][i] <= dv_ff[l][Q_W-1][i];
            end else if (dv_ff[l][Q_W-1][i][W-1]) begin
               ov_ff[l][i] <= (~qv) + 1'b1;
            end else begin
               ov_ff[l][i] <= qv;
            end
         end
      end
   end

   assign out_valid = vld_ff[LAT-1];
   assign out_vec   = ov_ff;
   assign out_deg   = od_ff;
   assign out_side  = side_ff[LAT-1];

endmodule

`default_nettype wire

// ===== hw/rtl/lavm_cross.sv =====
// pipelined fixed-point cross product: multiply, round, subtract
`default_nettype none

module lavm_cross #(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  lavm_pkg::vec_type a,
   input  lavm_pkg::vec_type b,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output lavm_pkg::vec_type out_vec,
   output logic [SIDE_W-1:0] out_side
);
   import lavm_pkg::*;

   logic [2:0]              vld_ff;
   logic [SIDE_W-1:0]       side_ff [3];
   logic [5:0][PROD_W-1:0]  pm_ff;
   logic [5:0]              pn_ff;
   word_type                pr_ff [6];
   vec_type                 o_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      int j;
      int k;
      side_ff[0] <= in_side;
      side_ff[1] <= side_ff[0];
      side_ff[2] <= side_ff[1];
      // magnitude products, o_i = a_j*b_k - a_k*b_j
      for (int i = 0; i < 3; i++) begin
         j = (i == 2) ? 0 : i + 1;
         k = (i == 0) ? 2 : i - 1;
         pm_ff[2*i]   <= mag_word(a[j]) * mag_word(b[k]);
         pn_ff[2*i]   <= a[j][WORD_BITS-1] ^ b[k][WORD_BITS-1];
         pm_ff[2*i+1] <= mag_word(a[k]) * mag_word(b[j]);
         pn_ff[2*i+1] <= a[k][WORD_BITS-1] ^ b[j][WORD_BITS-1];
      end
      // rounding
      for (int p = 0; p < 6; p++) begin
         pr_ff[p] <= round_prod(pm_ff[p], pn_ff[p]);
      end
      // difference
      for (int i = 0; i < 3; i++) begin
         o_ff[i] <= sat_word({pr_ff[2*i][WORD_BITS-1], pr_ff[2*i]}
                             - {pr_ff[2*i+1][WORD_BITS-1], pr_ff[2*i+1]});
      end
   end

   assign out_valid = vld_ff[2];
   assign out_vec   = o_ff;
   assign out_side  = side_ff[2];

endmodule

`default_nettype wire

// ===== hw/rtl/look_at_view_matrix.sv =====
// look-at view matrix: top level with register port, pipeline and row sequencer
//
//  channel   | ports                              | handshake
//  ----------+------------------------------------+------------------------------
//  request   | req_eye_*, req_target_*, req_up_*  | start high while busy low
//  response  | rsp_row_index, rsp_col0..3, last   | rsp_valid high with each row
//  registers | csr_psel .. csr_prdata             | setup + access, pready high
//
// items are paced by busy: the four matrix rows share the single result port
// row 0 appears once the item has passed the stages below, rows 1 to 3 follow in order
// (input capture, two normalizers of 57 stages, two cross products of 3, row sequencer)
// busy is raised by an accept and stays high until the gap counter runs down
// reset clears valid bits and the row sequencer, and sets the threshold to 1
// the result side is never stalled, so the pipeline runs free
`default_nettype none

module look_at_view_matrix (
   input  logic                clock,
   input  logic                reset,
   // request
   input  logic                start,
   output logic                busy,
   input  lavm_pkg::word_type  req_eye_x,
   input  lavm_pkg::word_type  req_eye_y,
   input  lavm_pkg::word_type  req_eye_z,
   input  lavm_pkg::word_type  req_target_x,
   input  lavm_pkg::word_type  req_target_y,
   input  lavm_pkg::word_type  req_target_z,
   input  lavm_pkg::word_type  req_up_hint_x,
   input  lavm_pkg::word_type  req_up_hint_y,
   input  lavm_pkg::word_type  req_up_hint_z,
   // response
   output logic                rsp_valid,
   output logic [1:0]          rsp_row_index,
   output lavm_pkg::word_type  rsp_col0,
   output lavm_pkg::word_type  rsp_col1,
   output lavm_pkg::word_type  rsp_col2,
   output lavm_pkg::word_type  rsp_col3,
   output logic                rsp_last_row,
   // register port
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);
   import lavm_pkg::*;

   localparam logic       REG_THR  = 1'b0;
   localparam logic [1:0] ITEM_GAP = 2'd3;
   localparam int         VB       = $bits(vec_type);

   logic [THR_W-1:0] thr_ff;
   logic [1:0]       gap_ff;
   logic             accept;

   logic             a_vld_ff;
   vec_type          eye_ff;
   vec_type          fwd_ff;
   vec_type          hint_ff;

   vec_type          n1_in [2];
   vec_type          n1_out [2];
   logic [1:0]       n1_deg;
   logic             n1_vld;
   logic [VB-1:0]    n1_side;

   vec_type          up_sel;
   logic             c1_vld;
   vec_type          c1_out;
   logic [2*VB-1:0]  c1_side;

   vec_type          n2_in [1];
   vec_type          n2_out [1];
   logic             n2_vld;
   logic [2*VB-1:0]  n2_side;

   logic             c2_vld;
   vec_type          c2_out;
   logic [3*VB-1:0]  c2_side;

   vec_type          mr_ff;
   vec_type          mu_ff;
   vec_type          mf_ff;
   vec_type          me_ff;
   logic             act_ff;
   logic [1:0]       row_ff;

   // register port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_THR) ? 32'(thr_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_W'(1);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == REG_THR) begin
         thr_ff <= csr_pwdata[THR_W-1:0];
      end
   end

   // accept pacing: a new item is taken only while busy is low
   assign accept = start && !busy;
   assign busy   = (gap_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff   <= '0;
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= accept;
         if (accept) begin
            gap_ff <= ITEM_GAP;
         end else if (gap_ff != '0) begin
            gap_ff <= gap_ff - 1'b1;
         end
      end
   end

   // input capture and forward difference
   always_ff @(posedge clock) begin
      if (accept) begin
         eye_ff  <= {req_eye_z, req_eye_y, req_eye_x};
         hint_ff <= {req_up_hint_z, req_up_hint_y, req_up_hint_x};
         fwd_ff[0] <= sat_word({req_target_x[WORD_BITS-1], req_target_x}
                               - {req_eye_x[WORD_BITS-1], req_eye_x});
         fwd_ff[1] <= sat_word({req_target_y[WORD_BITS-1], req_target_y}
                               - {req_eye_y[WORD_BITS-1], req_eye_y});
         fwd_ff[2] <= sat_word({req_target_z[WORD_BITS-1], req_target_z}
                               - {req_eye_z[WORD_BITS-1], req_eye_z});
      end
   end

   // normalize forward and up hint together
   assign n1_in[0] = fwd_ff;
   assign n1_in[1] = hint_ff;

   lavm_norm #(.NVEC(2), .SIDE_W(VB)) u_norm1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_vld_ff),
      .in_vec    (n1_in),
      .thr       (thr_ff),
      .in_side   (eye_ff),
      .out_valid (n1_vld),
      .out_vec   (n1_out),
      .out_deg   (n1_deg),
      .out_side  (n1_side)
   );

   // short up hint falls back to +y
   always_comb begin
      if (n1_deg[1]) begin
         up_sel    = '0;
         up_sel[1] = ONE_Q;
      end else begin
         up_sel = n1_out[1];
      end
   end

   // right = up x forward
   lavm_cross #(.SIDE_W(2*VB)) u_cross1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (n1_vld),
      .a         (up_sel),
      .b         (n1_out[0]),
      .in_side   ({n1_side, n1_out[0]}),
      .out_valid (c1_vld),
      .out_vec   (c1_out),
      .out_side  (c1_side)
   );

   assign n2_in[0] = c1_out;

   lavm_norm #(.NVEC(1), .SIDE_W(2*VB)) u_norm2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c1_vld),
      .in_vec    (n2_in),
      .thr       (thr_ff),
      .in_side   (c1_side),
      .out_valid (n2_vld),
      .out_vec   (n2_out),
      .out_deg   (),
      .out_side  (n2_side)
   );

   // corrected up = forward x right
   lavm_cross #(.SIDE_W(3*VB)) u_cross2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (n2_vld),
      .a         (n2_side[VB-1:0]),
      .b         (n2_out[0]),
      .in_side   ({n2_side, n2_out[0]}),
      .out_valid (c2_vld),
      .out_vec   (c2_out),
      .out_side  (c2_side)
   );

   // matrix capture
   always_ff @(posedge clock) begin
      if (c2_vld) begin
         mr_ff <= c2_side[VB-1:0];
         mu_ff <= c2_out;
         for (int i = 0; i < 3; i++) begin
            mf_ff[i] <= sat_word({(WORD_BITS+1){1'b0}}
                                 - {c2_side[VB+i*WORD_BITS+WORD_BITS-1],
                                    c2_side[VB+i*WORD_BITS +: WORD_BITS]});
            me_ff[i] <= sat_word({(WORD_BITS+1){1'b0}}
                                 - {c2_side[2*VB+i*WORD_BITS+WORD_BITS-1],
                                    c2_side[2*VB+i*WORD_BITS +: WORD_BITS]});
         end
      end
   end

   // row sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         row_ff <= ROW_RIGHT;
      end else if (c2_vld) begin
         act_ff <= 1'b1;
         row_ff <= ROW_RIGHT;
      end else if (act_ff) begin
         if (row_ff == ROW_TRANS) act_ff <= 1'b0;
         row_ff <= row_ff + 1'b1;
      end
   end

   // row select
   always_comb begin
      unique case (row_ff)
         ROW_RIGHT: begin
            rsp_col0 = mr_ff[0];
            rsp_col1 = mr_ff[1];
            rsp_col2 = mr_ff[2];
            rsp_col3 = '0;
         end
         ROW_UP: begin
            rsp_col0 = mu_ff[0];
            rsp_col1 = mu_ff[1];
            rsp_col2 = mu_ff[2];
            rsp_col3 = '0;
         end
         ROW_BACK: begin
            rsp_col0 = mf_ff[0];
            rsp_col1 = mf_ff[1];
            rsp_col2 = mf_ff[2];
            rsp_col3 = '0;
         end
         ROW_TRANS: begin
            rsp_col0 = me_ff[0];
            rsp_col1 = me_ff[1];
            rsp_col2 = me_ff[2];
            rsp_col3 = ONE_Q;
         end
         default: begin
            rsp_col0 = '0;
            rsp_col1 = '0;
            rsp_col2 = '0;
            rsp_col3 = '0;
         end
      endcase
   end

   assign rsp_valid     = act_ff;
   assign rsp_row_index = row_ff;
   assign rsp_last_row  = (row_ff == ROW_TRANS);

endmodule

`default_nettype wire

// ===== hw/rtl/lavm_check.sv =====
// port-level checks for the look-at matrix block, bound to the top level
`default_nettype none

module lavm_check (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input logic [1:0]          rsp_row_index,
   input lavm_pkg::word_type  rsp_col3,
   input logic                rsp_last_row
);
   import lavm_pkg::*;

   // an accepted item holds off the next one
   a_pace: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accept not followed by busy");

   // rows come out in order without gaps
   a_row_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_index != ROW_TRANS |=>
         rsp_valid && rsp_row_index == $past(rsp_row_index) + 2'd1)
      else $error("row sequence broken");

   // a matrix starts at row 0
   a_row_first: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_row_index == ROW_RIGHT)
      else $error("matrix did not start at row 0");

   // last flag marks the translation row
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last_row == (rsp_row_index == ROW_TRANS))
      else $error("last_row flag wrong");

   // homogeneous column
   a_col3: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_col3 == ((rsp_row_index == ROW_TRANS) ? ONE_Q : '0))
      else $error("column 3 wrong");

endmodule

bind look_at_view_matrix lavm_check u_check (.*);

`default_nettype wire
